// ----- rtl/gbn_pkg.sv -----
// Shared types and constants of the go-back-N link controller.
package gbn_pkg;

  localparam int CMD_W     = 3;
  localparam int KIND_W    = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] TIMEOUT_RESET   = 16'd1000;
  localparam logic [CFG_W-1:0] ACK_DELAY_RESET = 16'd200;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND = 3'd0,
    CMD_DATA = 3'd1,
    CMD_ACK  = 3'd2,
    CMD_NAK  = 3'd3,
    CMD_BAD  = 3'd4,
    CMD_TICK = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS    = 3'd0,
    KIND_SEND_DATA = 3'd1,
    KIND_SEND_ACK  = 3'd2,
    KIND_SEND_NAK  = 3'd3,
    KIND_DELIVER   = 3'd4,
    KIND_REJECT    = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT   = 1'd0,
    REG_ACK_DELAY = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CHECK  = 2'd1,
    ST_REPORT = 2'd2,
    ST_RESEND = 2'd3
  } state_t;

endpackage

// ----- rtl/go_back_n_link_controller_unit.sv -----
// Go-back-N link controller: sender window, in-order receiver and timers.
//
// Every command except a tick is handled in the cycle it is accepted and
// gives one result, so such items are taken one per cycle while the output
// register drains. A tick that resends nothing goes through these steps:
// the send-time memory makes a registered read of the oldest frame's stamp,
// the check state compares it with the timeout, and the report state puts
// out the result. A tick that triggers a go-back resend makes the same read
// and check, then puts out one frame per cycle while the output register
// drains, up to 2^SEQ_BITS-1 of them, each restamped in the memory. The
// output register takes one result per cycle, so a stalled consumer holds
// back every kind of item. Configuration writes are always taken.
module go_back_n_link_controller_unit
  import gbn_pkg::*;
#(
  parameter int SEQ_BITS  = 3,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [SEQ_BITS-1:0]  frame_seq,
  input  logic [SEQ_BITS-1:0]  frame_ack,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    kind,
  output logic [SEQ_BITS-1:0]  out_seq,
  output logic [SEQ_BITS-1:0]  out_ack,
  output logic                 last,
  output logic [SEQ_BITS-1:0]  outstanding,
  output logic                 window_open,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = 1 << SEQ_BITS;
  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam logic [SEQ_BITS-1:0] WINDOW_MAX = '1;
  localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

  state_t state, state_next;

  logic [CFG_W-1:0]     timeout_ticks;
  logic [CFG_W-1:0]     ack_delay_ticks;
  logic [SEQ_BITS-1:0]  next_to_send, next_to_send_next;
  logic [SEQ_BITS-1:0]  oldest_unacked, oldest_unacked_next;
  logic [SEQ_BITS-1:0]  expected_in, expected_in_next;
  logic [SEQ_BITS-1:0]  unacked_count, unacked_count_next;
  logic                 ack_pending, ack_pending_next;
  logic [CFG_W-1:0]     ack_countdown, ack_countdown_next;
  logic [TIME_BITS-1:0] now_ticks, now_ticks_next;
  logic [SEQ_BITS-1:0]  remaining, remaining_next;
  kind_t                tick_kind, tick_kind_next;

  logic                 ram_we, ram_re;
  logic [SEQ_BITS-1:0]  ram_waddr;
  logic [TIME_BITS-1:0] ram_rdata;

  logic                 load;
  kind_t                ld_kind;
  logic [SEQ_BITS-1:0]  ld_seq, ld_ack, ld_cnt;
  logic                 ld_last;
  kind_t                out_kind;

  logic                 out_free, accept;
  logic [SEQ_BITS-1:0]  ack_dist;
  logic                 ack_ok;
  logic [TIME_BITS-1:0] age;
  logic [CFG_W-1:0]     limit;
  logic                 timed_out;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // A cumulative ack retires frames only if it lands inside the window.
  assign ack_dist = frame_ack - oldest_unacked;
  assign ack_ok   = (ack_dist != '0) && (ack_dist <= unacked_count);

  // now_ticks has already advanced when the stamp comes back from the RAM.
  assign age       = now_ticks - ram_rdata;
  assign limit     = (timeout_ticks == '0) ? CFG_W'(1) : timeout_ticks;
  assign timed_out = (unacked_count != '0) && (CMP_W'(age) >= CMP_W'(limit));

  gbn_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (DEPTH)
  ) u_send_time (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (now_ticks),
    .re    (ram_re),
    .raddr (oldest_unacked),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd_t'(command) == CMD_TICK)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = timed_out ? ST_RESEND : ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESEND: begin
        if (out_free && (remaining == SEQ_ONE)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    next_to_send_next   = next_to_send;
    oldest_unacked_next = oldest_unacked;
    expected_in_next    = expected_in;
    unacked_count_next  = unacked_count;
    ack_pending_next    = ack_pending;
    ack_countdown_next  = ack_countdown;
    now_ticks_next      = now_ticks;
    remaining_next      = remaining;
    tick_kind_next      = tick_kind;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_waddr           = next_to_send;
    load                = 1'b0;
    ld_kind             = KIND_STATUS;
    ld_seq              = next_to_send;
    ld_ack              = expected_in;
    ld_cnt              = unacked_count;
    ld_last             = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(command))
            CMD_SEND: begin
              load = 1'b1;
              if (unacked_count == WINDOW_MAX) begin
                ld_kind = KIND_REJECT;
              end else begin
                ram_we             = 1'b1;
                ack_pending_next   = 1'b0;
                next_to_send_next  = next_to_send + SEQ_ONE;
                unacked_count_next = unacked_count + SEQ_ONE;
                ld_kind            = KIND_SEND_DATA;
                ld_cnt             = unacked_count + SEQ_ONE;
              end
            end
            CMD_DATA: begin
              load = 1'b1;
              if (frame_seq == expected_in) begin
                ld_kind          = KIND_DELIVER;
                ld_seq           = frame_seq;
                expected_in_next = expected_in + SEQ_ONE;
                ld_ack           = expected_in + SEQ_ONE;
                if (!ack_pending) begin
                  ack_pending_next   = 1'b1;
                  ack_countdown_next = ack_delay_ticks;
                end
              end
              if (ack_ok) begin
                unacked_count_next  = unacked_count - ack_dist;
                oldest_unacked_next = frame_ack;
                ld_cnt              = unacked_count - ack_dist;
              end
            end
            CMD_ACK: begin
              load = 1'b1;
              if (ack_ok) begin
                unacked_count_next  = unacked_count - ack_dist;
                oldest_unacked_next = frame_ack;
                ld_cnt              = unacked_count - ack_dist;
              end
            end
            CMD_BAD: begin
              load    = 1'b1;
              ld_kind = KIND_SEND_NAK;
              ld_seq  = frame_seq;
            end
            CMD_TICK: begin
              now_ticks_next = now_ticks + TIME_BITS'(1);
              ram_re         = 1'b1;
            end
            default: load = 1'b1;
          endcase
        end
      end
      ST_CHECK: begin
        if (timed_out) begin
          next_to_send_next = oldest_unacked;
          remaining_next    = unacked_count;
        end else if (ack_pending) begin
          if (ack_countdown <= CFG_W'(1)) begin
            ack_countdown_next = '0;
            ack_pending_next   = 1'b0;
            tick_kind_next     = KIND_SEND_ACK;
          end else begin
            ack_countdown_next = ack_countdown - CFG_W'(1);
            tick_kind_next     = KIND_STATUS;
          end
        end else begin
          tick_kind_next = KIND_STATUS;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = tick_kind;
          ld_seq  = (tick_kind == KIND_SEND_ACK) ? '0 : next_to_send;
        end
      end
      ST_RESEND: begin
        if (out_free) begin
          load              = 1'b1;
          ld_kind           = KIND_SEND_DATA;
          ld_last           = (remaining == SEQ_ONE);
          ram_we            = 1'b1;
          ack_pending_next  = 1'b0;
          next_to_send_next = next_to_send + SEQ_ONE;
          remaining_next    = remaining - SEQ_ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      timeout_ticks   <= TIMEOUT_RESET;
      ack_delay_ticks <= ACK_DELAY_RESET;
      next_to_send    <= '0;
      oldest_unacked  <= '0;
      expected_in     <= '0;
      unacked_count   <= '0;
      ack_pending     <= 1'b0;
      ack_countdown   <= '0;
      now_ticks       <= '0;
      remaining       <= '0;
      tick_kind       <= KIND_STATUS;
      out_valid       <= 1'b0;
    end else begin
      state          <= state_next;
      next_to_send   <= next_to_send_next;
      oldest_unacked <= oldest_unacked_next;
      expected_in    <= expected_in_next;
      unacked_count  <= unacked_count_next;
      ack_pending    <= ack_pending_next;
      ack_countdown  <= ack_countdown_next;
      now_ticks      <= now_ticks_next;
      remaining      <= remaining_next;
      tick_kind      <= tick_kind_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_TIMEOUT:   timeout_ticks   <= cfg_data;
          REG_ACK_DELAY: ack_delay_ticks <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // The result payload holds while a transfer is stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind    <= ld_kind;
      out_seq     <= ld_seq;
      out_ack     <= ld_ack;
      last        <= ld_last;
      outstanding <= ld_cnt;
      window_open <= (ld_cnt != WINDOW_MAX);
    end
  end

  assign kind = out_kind;

endmodule

// ----- rtl/gbn_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module gbn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gbn_checker.sv -----
// Port-level checker for the go-back-N link controller, bound to the top level.
module gbn_checker
  import gbn_pkg::*;
#(
  parameter int SEQ_BITS = 3
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   kind,
  input logic [SEQ_BITS-1:0] out_seq,
  input logic                last,
  input logic [SEQ_BITS-1:0] outstanding,
  input logic                window_open
);

  // A stalled result keeps its contents until the transfer happens.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_seq)
      && $stable(last))
    else $error("result changed while stalled");

  a_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_open == !(&outstanding))
    else $error("window_open disagrees with outstanding count");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REJECT) |-> !window_open && last)
    else $error("reject issued with an open window");

  a_ack_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SEND_ACK) |-> (out_seq == '0) && last)
    else $error("standalone ack carries a sequence number");

  // No new item is taken while a multi-result step is still being reported.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken in the middle of a step");

endmodule

bind go_back_n_link_controller_unit gbn_checker #(
  .SEQ_BITS (SEQ_BITS)
) u_gbn_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .out_seq     (out_seq),
  .last        (last),
  .outstanding (outstanding),
  .window_open (window_open)
);
